/* rtl/heat_stencil_3d_sweep_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the heat stencil sweep
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HEAT_STENCIL_3D_SWEEP_DEFINES_SVH
`define HEAT_STENCIL_3D_SWEEP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hss_pkg.sv */
// ----------------------------------------------------------------------------
// Heat stencil sweep package
// Beat types, register indexes and fixed widths of the stencil block.
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned TOL_W      = 31;
  localparam int unsigned EXT_X_W    = 9;
  localparam int unsigned EXT_YZ_W   = 7;
  localparam int unsigned DIFF_W     = 36;
  localparam int unsigned GAIN_HI_W  = 12;
  localparam int unsigned GAIN_LO_W  = 20;

  localparam logic FUNC_GRID = 1'b0;
  localparam logic FUNC_PAD  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_GAIN     = 3'd0,
    REG_BOUNDARY_VALUE = 3'd1,
    REG_TOLERANCE      = 3'd2,
    REG_EXTENT_X       = 3'd3,
    REG_EXTENT_Y       = 3'd4,
    REG_EXTENT_Z       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              func;
    logic signed [31:0] cell_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic              sweep_end;
    logic              reached;
  } out_beat_t;

endpackage

/* rtl/heat_stencil_3d_sweep.sv */
// ----------------------------------------------------------------------------
// Seven-point 3D heat stencil sweep: one grid point per cycle while not stalled, a rate set by
// the single write and two reads per cycle of its read-modify-write, two-plane RAM. A result
// passes stages p1 to p5 and the output register; the first plane gives no results.
// Synchronous active-low reset sets config, flags and counters; data registers and RAMs are kept.
// ----------------------------------------------------------------------------
`include "heat_stencil_3d_sweep_defines.svh"

module heat_stencil_3d_sweep #(
  parameter int unsigned MAX_X = 256,
  parameter int unsigned MAX_Y = 64,
  parameter int unsigned MAX_Z = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hss_pkg::in_beat_t                in_beat,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hss_pkg::out_beat_t               out_beat,
  input  logic                             cfg_we,
  input  logic [hss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hss_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned XW  = $clog2(MAX_X);
  localparam int unsigned EXW = $clog2(MAX_X + 1);
  localparam int unsigned YW  = $clog2(MAX_Y);
  localparam int unsigned EYW = $clog2(MAX_Y + 1);
  localparam int unsigned ZW  = $clog2(MAX_Z);
  localparam int unsigned EZW = $clog2(MAX_Z + 1);
  localparam int unsigned OW  = $clog2(MAX_Y * MAX_Z);
  localparam int unsigned PW  = $clog2(MAX_Y * MAX_Z + 1);
  localparam int unsigned SUW = PW + 1;
  localparam int unsigned AW  = OW + 1;
  localparam int unsigned AD  = 2 ** AW;
  localparam int unsigned BW  = $clog2(2 * MAX_Z);
  localparam int unsigned BD  = 2 ** BW;
  localparam int unsigned DW  = hss_pkg::DIFF_W;
  localparam int unsigned HPW = DW + hss_pkg::GAIN_HI_W + 1;
  localparam int unsigned LPW = DW + hss_pkg::GAIN_LO_W + 1;
  localparam int unsigned SW  = HPW + 2;

  typedef struct packed {
    logic res;
    logic last;
  } stage_ctl_t;

  typedef struct packed {
    logic left;
    logic up;
    logic down;
    logic top;
    logic bot;
  } nbr_mask_t;

  // Configuration registers
  logic [31:0]                       alpha_r;
  logic signed [31:0]                bound_r;
  logic [hss_pkg::TOL_W-1:0]         tol_r;
  logic [hss_pkg::EXT_X_W-1:0]       ext_x_r;
  logic [hss_pkg::EXT_YZ_W-1:0]      ext_y_r;
  logic [hss_pkg::EXT_YZ_W-1:0]      ext_z_r;
  logic                              ext_wr;

  logic [EXW-1:0] ex;
  logic [EYW-1:0] ey;
  logic [EZW-1:0] ez;
  logic [PW-1:0]  plane;

  // Stream counters
  logic           loaded_r, loaded_nxt;
  logic [OW-1:0]  woff_r, woff_nxt;
  logic           wpar_r, wpar_nxt;
  logic [XW-1:0]  out_x_r, out_x_nxt;
  logic [YW-1:0]  out_y_r, out_y_nxt;
  logic [ZW-1:0]  out_z_r, out_z_nxt;

  logic               adv, in_fire;
  logic signed [31:0] v_in;
  logic               x_more, y_more, z_more, woff_last, sweep_last;
  logic [SUW-1:0]     u_sum, u_off;
  logic               u_wrap;
  logic [AW-1:0]      wr_addr, s_addr;

  // Memories
  logic signed [31:0] win_mem [AD];
  logic signed [31:0] line_mem [BD];
  logic signed [31:0] rd_left_r, rd_s_r, rb1_r, rb2_r;
  logic [BW-1:0]      bw_r;
  logic [EZW:0]       ez2;

  // Pipeline
  logic               p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r, p5_vld_r;
  stage_ctl_t         p1_ctl_r, p2_ctl_r, p3_ctl_r, p4_ctl_r, p5_ctl_r;
  nbr_mask_t          p1_msk_r, p2_msk_r;
  logic signed [31:0] p1_right_r, p2_right_r, p2_left_r, p2_down_r;
  logic signed [31:0] hist1_r, hist2_r;
  logic signed [31:0] n_c, n_left, n_up, n_down, n_top, n_bot;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] p3_d_r;
  logic signed [31:0]   p3_c_r, p4_c_r;
  logic signed [HPW-1:0] p4_hi_r;
  logic signed [LPW-1:0] p4_lo_r;
  logic signed [SW-1:0]  upd_sum;
  logic                  upd_ovf;
  logic signed [31:0]    upd_sat, p5_res_r;
  logic signed [32:0]    err;
  logic [32:0]           err_mag;
  logic                  hit, flag_new;
  logic                  reached_flag_r;
  logic                  out_valid_r;
  hss_pkg::out_beat_t    out_beat_r;

  always_comb begin
    if (ext_x_r < 9'd2) begin
      ex = EXW'(2);
    end else if (32'(ext_x_r) > MAX_X) begin
      ex = EXW'(MAX_X);
    end else begin
      ex = EXW'(ext_x_r);
    end
    if (ext_y_r < 7'd2) begin
      ey = EYW'(2);
    end else if (32'(ext_y_r) > MAX_Y) begin
      ey = EYW'(MAX_Y);
    end else begin
      ey = EYW'(ext_y_r);
    end
    if (ext_z_r < 7'd2) begin
      ez = EZW'(2);
    end else if (32'(ext_z_r) > MAX_Z) begin
      ez = EZW'(MAX_Z);
    end else begin
      ez = EZW'(ext_z_r);
    end
    plane = PW'(PW'(ey) * PW'(ez));
  end

  assign ext_wr = cfg_we && (cfg_index == hss_pkg::REG_EXTENT_X ||
                             cfg_index == hss_pkg::REG_EXTENT_Y ||
                             cfg_index == hss_pkg::REG_EXTENT_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= '0;
      bound_r <= '0;
      tol_r   <= '0;
      ext_x_r <= hss_pkg::EXT_X_W'(2);
      ext_y_r <= hss_pkg::EXT_YZ_W'(2);
      ext_z_r <= hss_pkg::EXT_YZ_W'(2);
    end else if (cfg_we) begin
      unique case (hss_pkg::cfg_reg_t'(cfg_index))
        hss_pkg::REG_ALPHA_GAIN:     alpha_r <= cfg_wdata;
        hss_pkg::REG_BOUNDARY_VALUE: bound_r <= $signed(cfg_wdata);
        hss_pkg::REG_TOLERANCE:      tol_r   <= cfg_wdata[hss_pkg::TOL_W-1:0];
        hss_pkg::REG_EXTENT_X:       ext_x_r <= cfg_wdata[hss_pkg::EXT_X_W-1:0];
        hss_pkg::REG_EXTENT_Y:       ext_y_r <= cfg_wdata[hss_pkg::EXT_YZ_W-1:0];
        hss_pkg::REG_EXTENT_Z:       ext_z_r <= cfg_wdata[hss_pkg::EXT_YZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign in_fire  = in_valid && adv;
  assign v_in     = (in_beat.func == hss_pkg::FUNC_PAD) ? bound_r : in_beat.cell_value;

  assign x_more     = (EXW'(out_x_r) + EXW'(1)) < ex;
  assign y_more     = (EYW'(out_y_r) + EYW'(1)) < ey;
  assign z_more     = (EZW'(out_z_r) + EZW'(1)) < ez;
  assign woff_last  = (PW'(woff_r) + PW'(1)) == plane;
  assign sweep_last = loaded_r && !x_more && !y_more && !z_more;

  assign u_sum   = SUW'(woff_r) + SUW'(ez);
  assign u_wrap  = u_sum >= SUW'(plane);
  assign u_off   = u_wrap ? u_sum - SUW'(plane) : u_sum;
  assign wr_addr = {wpar_r, woff_r};
  assign s_addr  = {!(wpar_r ^ u_wrap), u_off[OW-1:0]};

  always_comb begin
    loaded_nxt = loaded_r;
    woff_nxt   = woff_r;
    wpar_nxt   = wpar_r;
    out_x_nxt  = out_x_r;
    out_y_nxt  = out_y_r;
    out_z_nxt  = out_z_r;
    if (ext_wr || (in_fire && sweep_last)) begin
      loaded_nxt = 1'b0;
      woff_nxt   = '0;
      wpar_nxt   = 1'b0;
      out_x_nxt  = '0;
      out_y_nxt  = '0;
      out_z_nxt  = '0;
    end else if (in_fire) begin
      woff_nxt = woff_last ? '0 : woff_r + OW'(1);
      wpar_nxt = wpar_r ^ woff_last;
      if (!loaded_r) begin
        loaded_nxt = woff_last;
      end else if (z_more) begin
        out_z_nxt = out_z_r + ZW'(1);
      end else begin
        out_z_nxt = '0;
        if (y_more) begin
          out_y_nxt = out_y_r + YW'(1);
        end else begin
          out_y_nxt = '0;
          out_x_nxt = out_x_r + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      woff_r   <= '0;
      wpar_r   <= 1'b0;
      out_x_r  <= '0;
      out_y_r  <= '0;
      out_z_r  <= '0;
    end else begin
      loaded_r <= loaded_nxt;
      woff_r   <= woff_nxt;
      wpar_r   <= wpar_nxt;
      out_x_r  <= out_x_nxt;
      out_y_r  <= out_y_nxt;
      out_z_r  <= out_z_nxt;
    end
  end

  // Plane RAM: the incoming plane overwrites the oldest one after its value is read.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_mem[wr_addr] <= v_in;
      rd_left_r        <= win_mem[wr_addr];
      rd_s_r           <= win_mem[s_addr];
    end
  end

  // Row delay line fed by the look-ahead read of the current plane.
  assign ez2 = {ez, 1'b0};

  always_ff @(posedge clk) begin
    if (adv && p1_vld_r) begin
      line_mem[bw_r] <= rd_s_r;
      rb1_r          <= line_mem[bw_r - BW'(ez) + BW'(1)];
      rb2_r          <= line_mem[bw_r - BW'(ez2)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= '0;
    end else if (adv && p1_vld_r) begin
      bw_r <= bw_r + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
      p5_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= in_fire;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
      p5_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_ctl_r.res  <= loaded_r;
      p1_ctl_r.last <= sweep_last;
      p1_msk_r.left <= out_x_r != '0;
      p1_msk_r.up   <= out_y_r != '0;
      p1_msk_r.down <= y_more;
      p1_msk_r.top  <= out_z_r != '0;
      p1_msk_r.bot  <= z_more;
      p1_right_r    <= x_more ? v_in : bound_r;
    end
    if (adv && p1_vld_r) begin
      p2_ctl_r    <= p1_ctl_r;
      p2_msk_r    <= p1_msk_r;
      p2_right_r  <= p1_right_r;
      p2_left_r   <= rd_left_r;
      p2_down_r   <= rd_s_r;
    end
    if (adv && p2_vld_r) begin
      hist1_r  <= rb1_r;
      hist2_r  <= hist1_r;
      p3_ctl_r <= p2_ctl_r;
      p3_d_r   <= diff;
      p3_c_r   <= n_c;
    end
    if (adv && p3_vld_r) begin
      p4_ctl_r <= p3_ctl_r;
      p4_c_r   <= p3_c_r;
      p4_hi_r  <= p3_d_r * $signed({1'b0, alpha_r[31:hss_pkg::GAIN_LO_W]});
      p4_lo_r  <= p3_d_r * $signed({1'b0, alpha_r[hss_pkg::GAIN_LO_W-1:0]});
    end
    if (adv && p4_vld_r) begin
      p5_ctl_r <= p4_ctl_r;
      p5_res_r <= upd_sat;
    end
  end

  always_comb begin
    n_c    = hist1_r;
    n_left = p2_msk_r.left ? p2_left_r : bound_r;
    n_up   = p2_msk_r.up   ? rb2_r     : bound_r;
    n_down = p2_msk_r.down ? p2_down_r : bound_r;
    n_top  = p2_msk_r.top  ? hist2_r   : bound_r;
    n_bot  = p2_msk_r.bot  ? rb1_r     : bound_r;
    diff   = DW'(n_left) + DW'(p2_right_r) + DW'(n_up) + DW'(n_down) + DW'(n_top)
           + DW'(n_bot) - (DW'(n_c) <<< 2) - (DW'(n_c) <<< 1);
  end

  always_comb begin
    upd_sum = SW'(p4_c_r) + SW'(p4_hi_r) + SW'(p4_lo_r >>> hss_pkg::GAIN_LO_W);
    upd_ovf = !((&upd_sum[SW-1:31]) || !(|upd_sum[SW-1:31]));
    if (upd_ovf) begin
      upd_sat = upd_sum[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      upd_sat = upd_sum[31:0];
    end
  end

  always_comb begin
    err      = 33'(p5_res_r) - 33'(bound_r);
    err_mag  = err[32] ? 33'(-err) : 33'(err);
    hit      = err_mag <= {2'b00, tol_r};
    flag_new = reached_flag_r || hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_flag_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (ext_wr) begin
        reached_flag_r <= 1'b0;
      end else if (adv && p5_vld_r && p5_ctl_r.res) begin
        reached_flag_r <= flag_new && !p5_ctl_r.last;
      end
      if (adv) begin
        out_valid_r <= p5_vld_r && p5_ctl_r.res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p5_vld_r && p5_ctl_r.res) begin
      out_beat_r.new_value <= p5_res_r;
      out_beat_r.sweep_end <= p5_ctl_r.last;
      out_beat_r.reached   <= flag_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `HSS_ASSERT_NOW(a_woff_in_plane, 1'b1, PW'(woff_r) < plane, "write offset outside plane")
  `HSS_ASSERT_NOW(a_z_in_range, 1'b1, EZW'(out_z_r) < ez, "output z position out of range")
  `HSS_ASSERT_NOW(a_idle_pos, !loaded_r, (out_x_r == '0) && (out_y_r == '0) && (out_z_r == '0), "output position moved during plane load")
  `HSS_ASSERT_NOW(a_end_clears_flag, out_valid_r && out_beat_r.sweep_end, !reached_flag_r, "reached flag kept past sweep end")

endmodule
